>>> rtl/text_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// text_token_lexer assertion macros
// shared property forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_TOKEN_LEXER_ASSERT_SVH
`define TEXT_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define TTL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// types and constants shared by the text token lexer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttl_pkg;

  localparam logic [1:0] CLS_SPACE = 2'd0;
  localparam logic [1:0] CLS_DIGIT = 2'd1;
  localparam logic [1:0] CLS_ALPHA = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [3:0] TK_LBRACE   = 4'd0;
  localparam logic [3:0] TK_RBRACE   = 4'd1;
  localparam logic [3:0] TK_LBRACKET = 4'd2;
  localparam logic [3:0] TK_RBRACKET = 4'd3;
  localparam logic [3:0] TK_COMMA    = 4'd4;
  localparam logic [3:0] TK_INTEGER  = 4'd5;
  localparam logic [3:0] TK_IDENT    = 4'd6;
  localparam logic [3:0] TK_PTR      = 4'd7;
  localparam logic [3:0] TK_ARR      = 4'd8;
  localparam logic [3:0] TK_U8       = 4'd9;
  localparam logic [3:0] TK_U16      = 4'd10;
  localparam logic [3:0] TK_U32      = 4'd11;
  localparam logic [3:0] TK_U64      = 4'd12;
  localparam logic [3:0] TK_EOF      = 4'd13;
  localparam logic [3:0] TK_ERROR    = 4'd14;

  localparam logic [23:0] KW_PTR = "ptr";
  localparam logic [23:0] KW_ARR = "arr";
  localparam logic [23:0] KW_U8  = {8'h00, "u8"};
  localparam logic [23:0] KW_U16 = "u16";
  localparam logic [23:0] KW_U32 = "u32";
  localparam logic [23:0] KW_U64 = "u64";

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] ch;
    logic [3:0] kind;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] ival;
    logic [15:0] start;
    logic [15:0] len;
    logic [3:0]  width;
    logic        last;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/ttl_front.sv
// ----------------------------------------------------------------------------
// ttl_front
// takes text bytes and registers each with its character class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttl_front import ttl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_text_byte,
  output      logic       push,
  output      item_t      push_item,
  input  wire logic       q_full
);

  logic  f_valid_r, f_valid_nxt;
  item_t f_item_r;
  item_t cls_item;
  logic  accept;

  always_comb begin
    cls_item.ch   = in_text_byte;
    cls_item.kind = TK_ERROR;
    if (in_text_byte == " " || in_text_byte == 8'h09 ||
        in_text_byte == 8'h0d || in_text_byte == 8'h0a) begin
      cls_item.cls = CLS_SPACE;
    end else if (in_text_byte >= "0" && in_text_byte <= "9") begin
      cls_item.cls = CLS_DIGIT;
    end else if ((in_text_byte >= "a" && in_text_byte <= "z") ||
                 (in_text_byte >= "A" && in_text_byte <= "Z") ||
                 in_text_byte == "_") begin
      cls_item.cls = CLS_ALPHA;
    end else begin
      cls_item.cls = CLS_OTHER;
      case (in_text_byte)
        "{":     cls_item.kind = TK_LBRACE;
        "}":     cls_item.kind = TK_RBRACE;
        "[":     cls_item.kind = TK_LBRACKET;
        "]":     cls_item.kind = TK_RBRACKET;
        ",":     cls_item.kind = TK_COMMA;
        8'h00:   cls_item.kind = TK_EOF;
        default: cls_item.kind = TK_ERROR;
      endcase
    end
  end

  assign push      = f_valid_r && !q_full;
  assign in_stall  = f_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= cls_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttl_queue.sv
// ----------------------------------------------------------------------------
// ttl_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttl_queue import ttl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  q_valid,
  output      item_t head
);

  item_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r, count_nxt;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttl_back.sv
// ----------------------------------------------------------------------------
// ttl_back
// lexer state, number accumulate, keyword match and token output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_token_lexer_assert.svh"

module ttl_back import ttl_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output      logic  q_pop,
  output      logic  out_valid,
  input  wire logic  out_stall,
  output      tok_t  out_tok
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_HALT  = 2'd3;

  logic [1:0]               mode_r, mode_nxt;
  logic [63:0]              acc_r, acc_nxt;
  logic [15:0]              tstart_r, tstart_nxt;
  logic [15:0]              tlen_r, tlen_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [23:0]              kwp_r, kwp_nxt;

  logic out_valid_r, out_valid_nxt;
  tok_t out_tok_r, out_tok_nxt;
  logic pend_valid_r, pend_valid_nxt;
  tok_t pend_tok_r, pend_tok_nxt;

  logic                      slot_free;
  logic                      is_num, is_word;
  logic [67:0]               mul10;
  logic [POSITION_BITS+15:0] pos_ext;
  logic [3:0]                id_kind;
  logic [3:0]                id_width;
  tok_t                      close_tok, own_tok, r0_tok, r1_tok;
  logic                      closing, classify, own_v, r0_v, r1_v;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && slot_free && !pend_valid_r;
  assign is_num    = (q_item.cls == CLS_DIGIT);
  assign is_word   = is_num || (q_item.cls == CLS_ALPHA);
  assign pos_ext   = {16'b0, pos_r};
  assign mul10     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, q_item.ch[3:0]};

  // keyword match on the pending identifier
  always_comb begin
    id_kind  = TK_IDENT;
    id_width = 4'd0;
    if (tlen_r == 16'd3) begin
      if (kwp_r == KW_PTR) begin
        id_kind = TK_PTR;
      end else if (kwp_r == KW_ARR) begin
        id_kind = TK_ARR;
      end else if (kwp_r == KW_U16) begin
        id_kind  = TK_U16;
        id_width = 4'd2;
      end else if (kwp_r == KW_U32) begin
        id_kind  = TK_U32;
        id_width = 4'd4;
      end else if (kwp_r == KW_U64) begin
        id_kind  = TK_U64;
        id_width = 4'd8;
      end
    end else if (tlen_r == 16'd2 && kwp_r == KW_U8) begin
      id_kind  = TK_U8;
      id_width = 4'd1;
    end
  end

  always_comb begin
    close_tok       = '0;
    close_tok.last  = 1'b0;
    if (mode_r == MODE_NUM) begin
      close_tok.kind = TK_INTEGER;
      close_tok.ival = acc_r;
    end else begin
      close_tok.kind  = id_kind;
      close_tok.width = id_width;
      if (id_kind == TK_IDENT) begin
        close_tok.start = tstart_r;
        close_tok.len   = tlen_r;
      end
    end
    own_tok      = '0;
    own_tok.kind = q_item.kind;
    own_tok.last = 1'b1;
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    pos_nxt    = pos_r;
    kwp_nxt    = kwp_r;
    closing    = 1'b0;
    classify   = 1'b0;
    case (mode_r)
      MODE_NUM: begin
        if (is_num) begin
          acc_nxt = (|mul10[67:64]) ? '1 : mul10[63:0];
        end else begin
          closing  = 1'b1;
          classify = 1'b1;
          acc_nxt  = '0;
        end
      end
      MODE_IDENT: begin
        if (is_word) begin
          if (tlen_r != 16'hffff) begin
            tlen_nxt = tlen_r + 16'd1;
          end
          kwp_nxt = {kwp_r[15:0], q_item.ch};
        end else begin
          closing  = 1'b1;
          classify = 1'b1;
        end
      end
      MODE_IDLE: begin
        classify = 1'b1;
      end
      default: begin
      end
    endcase
    if (mode_r != MODE_HALT) begin
      pos_nxt = pos_r + 1'b1;
    end
    if (classify) begin
      mode_nxt = MODE_IDLE;
      case (q_item.cls)
        CLS_DIGIT: begin
          mode_nxt = MODE_NUM;
          acc_nxt  = {60'b0, q_item.ch[3:0]};
        end
        CLS_ALPHA: begin
          mode_nxt   = MODE_IDENT;
          tstart_nxt = pos_ext[15:0];
          tlen_nxt   = 16'd1;
          kwp_nxt    = {16'b0, q_item.ch};
        end
        CLS_OTHER: begin
          if (q_item.kind == TK_EOF || q_item.kind == TK_ERROR) begin
            mode_nxt = MODE_HALT;
          end
        end
        default: begin
        end
      endcase
    end
    own_v = classify && (q_item.cls == CLS_OTHER);
  end

  always_comb begin
    r0_v   = closing || own_v;
    r1_v   = closing && own_v;
    r0_tok = closing ? close_tok : own_tok;
    if (closing && !own_v) begin
      r0_tok.last = 1'b1;
    end
    r1_tok = own_tok;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_tok_nxt    = out_tok_r;
    pend_valid_nxt = pend_valid_r;
    pend_tok_nxt   = pend_tok_r;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_tok_nxt    = pend_tok_r;
        pend_valid_nxt = 1'b0;
      end else if (q_pop && r0_v) begin
        out_valid_nxt  = 1'b1;
        out_tok_nxt    = r0_tok;
        pend_valid_nxt = r1_v;
        pend_tok_nxt   = r1_tok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      acc_r        <= '0;
      tstart_r     <= '0;
      tlen_r       <= '0;
      pos_r        <= '0;
      kwp_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r   <= mode_nxt;
        acc_r    <= acc_nxt;
        tstart_r <= tstart_nxt;
        tlen_r   <= tlen_nxt;
        pos_r    <= pos_nxt;
        kwp_r    <= kwp_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tok_r  <= out_tok_nxt;
    pend_tok_r <= pend_tok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

  `TTL_ASSERT_SAME(a_pend_needs_out, pend_valid_r, out_valid_r, "pending token without output")
  `TTL_ASSERT_SAME(a_first_has_second, out_valid_r && !out_tok_r.last, pend_valid_r, "lost second token")
  `TTL_ASSERT_NEXT(a_halt_sticks, mode_r == MODE_HALT, mode_r == MODE_HALT, "left halt without reset")
  `TTL_ASSERT_SAME(a_pop_needs_slot, q_pop, !pend_valid_r && slot_free, "pop with no output room")

endmodule

`default_nettype wire

>>> rtl/text_token_lexer.sv
// ----------------------------------------------------------------------------
// text_token_lexer
// streaming lexer: text bytes in, integer, identifier, keyword and
// punctuation, end-of-input and error tokens out
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    in_text_byte
// out      out  out_valid/out_stall  out_token_kind .. out_last_of_run
//
// one byte per cycle when nothing stalls; a byte that closes a pending token and
// gives its own token holds off the next pop until the second token is output
// a byte passes the front register, the queue and the output register to a token
// the four-entry queue lets the front keep taking bytes while the back stalls
// reset is synchronous and clears all control state; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_token_lexer import ttl_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_text_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  out_token_kind,
  output      logic [63:0] out_integer_value,
  output      logic [15:0] out_ident_start,
  output      logic [15:0] out_ident_length,
  output      logic [3:0]  out_prim_width,
  output      logic        out_last_of_run
);

  logic  push, q_full, q_pop, q_valid;
  item_t push_item, q_head;
  tok_t  tok;

  ttl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  ttl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  ttl_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (tok)
  );

  assign out_token_kind    = tok.kind;
  assign out_integer_value = tok.ival;
  assign out_ident_start   = tok.start;
  assign out_ident_length  = tok.len;
  assign out_prim_width    = tok.width;
  assign out_last_of_run   = tok.last;

endmodule

`default_nettype wire
